### hdl/lad_pkg.sv
// Package for the load anomaly detector: report kinds, severity codes,
// register indexes, reset values and the overshoot grading function.
// No dependencies.
`timescale 1ns / 1ps

package lad_pkg;

	localparam int HistoryDepthDefault = 64;

	localparam int LoadW   = 10;
	localparam int RunW    = 8;
	localparam int WindowW = 7;
	localparam int FreeW   = 48;
	localparam int MetricW = 28;
	localparam int CfgDataW = 10;
	localparam int CfgIndexW = 3;
	localparam int InDataW  = 72;
	localparam int OutDataW = 40;
	localparam int NumKinds = 5;

	localparam logic [RunW-1:0] RunMax = '1;

	// More than this many bytes lost over the window is a high-severity leak.
	localparam logic [FreeW-1:0] LeakHighBytes = 48'd536870912;
	// Lost bytes are reported in whole MiB.
	localparam int MibShift = 20;

	typedef enum logic [2:0] {
		KIND_CPU_SPIKE = 3'd0,
		KIND_CPU_RAMP  = 3'd1,
		KIND_MEM_SPIKE = 3'd2,
		KIND_MEM_LEAK  = 3'd3,
		KIND_OVERLOAD  = 3'd4
	} anomaly_kind_t;

	typedef enum logic [1:0] {
		SEV_LOW      = 2'd0,
		SEV_MEDIUM   = 2'd1,
		SEV_HIGH     = 2'd2,
		SEV_CRITICAL = 2'd3
	} severity_t;

	typedef enum logic [CfgIndexW-1:0] {
		REG_CPU_THRESHOLD  = 3'd0,
		REG_CPU_RUN_NEEDED = 3'd1,
		REG_MEM_THRESHOLD  = 3'd2,
		REG_MEM_RUN_NEEDED = 3'd3,
		REG_RAMP_DELTA     = 3'd4,
		REG_LEAK_WINDOW    = 3'd5
	} cfg_reg_t;

	localparam logic [LoadW-1:0]   CpuThresholdReset = 10'd900;
	localparam logic [RunW-1:0]    CpuRunNeededReset = 8'd3;
	localparam logic [LoadW-1:0]   MemThresholdReset = 10'd900;
	localparam logic [RunW-1:0]    MemRunNeededReset = 8'd3;
	localparam logic [LoadW-1:0]   RampDeltaReset    = 10'd300;
	localparam logic [WindowW-1:0] LeakWindowReset   = 7'd10;

	// Spike severity from the signed overshoot of a load over its threshold.
	function automatic severity_t grade(input logic [LoadW-1:0] value,
			input logic [LoadW-1:0] threshold);
		logic signed [LoadW:0] over;
		over = $signed({1'b0, value}) - $signed({1'b0, threshold});
		if (over >= 11'sd80) begin
			return SEV_CRITICAL;
		end else if (over >= 11'sd50) begin
			return SEV_HIGH;
		end else if (over >= 11'sd20) begin
			return SEV_MEDIUM;
		end
		return SEV_LOW;
	endfunction

endpackage

### hdl/lad_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module lad_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/load_anomaly_detector.sv
// Load anomaly detector top level: sample register, state update with the
// free-memory history, report sequencer and output register.
// Depends on lad_pkg and lad_ram.
//
//  channel  | direction | beat
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | one sample: cpu_load, mem_load, free_bytes
//  m_axis   | out       | one report: anomaly_kind, severity, metric; tlast
//  cfg      | in        | one register write, no handshake
//
// A sample moves from the input register to the report stage when that stage
// takes it, and the state and the history RAM are updated as it moves; the
// history RAM read issued then is ready when the sample reaches the report
// stage. The report stage hands one report per cycle to the output register
// while the output is not stalled, up to 5 reports per sample. A stalled
// output holds the report stage, which then holds the input register.
// Reset restores the register defaults and clears the counters; the history
// RAM needs no clearing, since only slots written since reset are read.
`timescale 1ns / 1ps

module load_anomaly_detector #(
	parameter int HISTORY_DEPTH = lad_pkg::HistoryDepthDefault
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// tdata: cpu_load [9:0], mem_load [19:10], free_bytes [67:20], zeros above
	input  logic [lad_pkg::InDataW-1:0]    s_axis_tdata,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// tdata: anomaly_kind [2:0], severity [4:3], metric [32:5], zeros above
	output logic [lad_pkg::OutDataW-1:0]   m_axis_tdata,
	output logic                           m_axis_tlast,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic                           cfg_wr_en,
	input  logic [lad_pkg::CfgIndexW-1:0]  cfg_index,
	input  logic [lad_pkg::CfgDataW-1:0]   cfg_data
);

	import lad_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int SW = $clog2(HISTORY_DEPTH + 1);
	localparam int CW = (SW > WindowW) ? SW : WindowW;
	localparam int IW = CW + 2;

	// Configuration registers.
	logic [LoadW-1:0]   cpu_threshold_q, mem_threshold_q, ramp_delta_q;
	logic [RunW-1:0]    cpu_run_needed_q, mem_run_needed_q;
	logic [WindowW-1:0] leak_window_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_threshold_q  <= CpuThresholdReset;
			cpu_run_needed_q <= CpuRunNeededReset;
			mem_threshold_q  <= MemThresholdReset;
			mem_run_needed_q <= MemRunNeededReset;
			ramp_delta_q     <= RampDeltaReset;
			leak_window_q    <= LeakWindowReset;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_CPU_THRESHOLD:  cpu_threshold_q  <= cfg_data[LoadW-1:0];
				REG_CPU_RUN_NEEDED: cpu_run_needed_q <= cfg_data[RunW-1:0];
				REG_MEM_THRESHOLD:  mem_threshold_q  <= cfg_data[LoadW-1:0];
				REG_MEM_RUN_NEEDED: mem_run_needed_q <= cfg_data[RunW-1:0];
				REG_RAMP_DELTA:     ramp_delta_q     <= cfg_data[LoadW-1:0];
				REG_LEAK_WINDOW:    leak_window_q    <= cfg_data[WindowW-1:0];
				default: ;
			endcase
		end
	end

	// Input register.
	logic             valid_s1;
	logic [LoadW-1:0] cpu_s1, mem_s1;
	logic [FreeW-1:0] free_s1;
	logic             adv_s1;
	logic             take_s2;
	logic             in_beat;

	assign s_axis_tready = !valid_s1 || take_s2;
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign adv_s1        = valid_s1 && take_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_beat) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			cpu_s1  <= s_axis_tdata[LoadW-1:0];
			mem_s1  <= s_axis_tdata[2*LoadW-1:LoadW];
			free_s1 <= s_axis_tdata[2*LoadW+FreeW-1:2*LoadW];
		end
	end

	// Sample state.
	logic [RunW-1:0]  cpu_run_q, mem_run_q;
	logic [LoadW-1:0] prev_cpu_q;
	logic [FreeW-1:0] prev_free_q;
	logic [SW-1:0]    samples_q, fall_run_q;
	logic [AW-1:0]    ptr_q;

	logic                  had_prev;
	logic [SW-1:0]         samples_next, fall_next;
	logic [AW-1:0]         ptr_next;
	logic [RunW-1:0]       cpu_run_next, mem_run_next;
	logic                  cpu_hot, mem_hot;
	logic signed [LoadW:0] rise;
	logic                  ramp_fire, ramp_high;
	logic [WindowW-1:0]    win, back;
	logic                  leak_fire;
	logic [IW-1:0]         idx_wide;
	logic [AW-1:0]         leak_idx;
	logic [NumKinds-1:0]   fire_mask;

	always_comb begin
		had_prev = samples_q != '0;

		if (!had_prev) begin
			fall_next = '0;
		end else if (free_s1 < prev_free_q) begin
			fall_next = (fall_run_q == SW'(HISTORY_DEPTH)) ? fall_run_q : fall_run_q + 1'b1;
		end else begin
			fall_next = '0;
		end

		if (!had_prev || ptr_q == AW'(HISTORY_DEPTH - 1)) begin
			ptr_next = '0;
		end else begin
			ptr_next = ptr_q + 1'b1;
		end

		samples_next = (samples_q == SW'(HISTORY_DEPTH)) ? samples_q : samples_q + 1'b1;

		cpu_hot = cpu_s1 >= cpu_threshold_q;
		mem_hot = mem_s1 >= mem_threshold_q;
		if (!cpu_hot) begin
			cpu_run_next = '0;
		end else begin
			cpu_run_next = (cpu_run_q == RunMax) ? cpu_run_q : cpu_run_q + 1'b1;
		end
		if (!mem_hot) begin
			mem_run_next = '0;
		end else begin
			mem_run_next = (mem_run_q == RunMax) ? mem_run_q : mem_run_q + 1'b1;
		end

		rise      = $signed({1'b0, cpu_s1}) - $signed({1'b0, prev_cpu_q});
		ramp_fire = had_prev && (rise >= $signed({1'b0, ramp_delta_q}));
		ramp_high = $signed({rise[LoadW], rise}) >= $signed({1'b0, ramp_delta_q, 1'b0});

		// A window of zero behaves as a window of one.
		win  = (leak_window_q == '0) ? WindowW'(1) : leak_window_q;
		back = win - 1'b1;
		leak_fire = (CW'(win) <= CW'(samples_next)) && (CW'(fall_next) >= CW'(back));

		// Slot of the oldest sample in the window; only meaningful on a leak.
		idx_wide = IW'(ptr_next) + IW'(HISTORY_DEPTH) - IW'(back);
		if (idx_wide >= IW'(HISTORY_DEPTH)) begin
			idx_wide = idx_wide - IW'(HISTORY_DEPTH);
		end
		leak_idx = idx_wide[AW-1:0];

		fire_mask = '0;
		fire_mask[KIND_CPU_SPIKE] = cpu_run_next >= cpu_run_needed_q;
		fire_mask[KIND_CPU_RAMP]  = ramp_fire;
		fire_mask[KIND_MEM_SPIKE] = mem_run_next >= mem_run_needed_q;
		fire_mask[KIND_MEM_LEAK]  = leak_fire;
		fire_mask[KIND_OVERLOAD]  = cpu_hot && mem_hot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_run_q  <= '0;
			mem_run_q  <= '0;
			prev_cpu_q <= '0;
			samples_q  <= '0;
			fall_run_q <= '0;
			ptr_q      <= '0;
		end else if (adv_s1) begin
			cpu_run_q  <= cpu_run_next;
			mem_run_q  <= mem_run_next;
			prev_cpu_q <= cpu_s1;
			samples_q  <= samples_next;
			fall_run_q <= fall_next;
			ptr_q      <= ptr_next;
		end
	end

	// The newest history entry is kept in a register, so the RAM serves
	// only the window read.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			prev_free_q <= free_s1;
		end
	end

	logic [FreeW-1:0] hist_rdata;

	lad_ram #(
		.WIDTH (FreeW),
		.DEPTH (HISTORY_DEPTH)
	) u_history (
		.clk   (clk),
		.we    (adv_s1),
		.waddr (ptr_next),
		.wdata (free_s1),
		.re    (adv_s1),
		.raddr (leak_idx),
		.rdata (hist_rdata)
	);

	// Report stage: one pending bit per kind, emitted lowest kind first.
	logic [NumKinds-1:0] mask_s2;
	severity_t           cpu_sev_s2, mem_sev_s2, ramp_sev_s2;
	logic [LoadW-1:0]    cpu_s2, mem_s2, rise_s2;
	logic [FreeW-1:0]    free_s2;
	logic                leak_one_s2;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			cpu_sev_s2  <= grade(cpu_s1, cpu_threshold_q);
			mem_sev_s2  <= grade(mem_s1, mem_threshold_q);
			ramp_sev_s2 <= ramp_high ? SEV_HIGH : SEV_MEDIUM;
			cpu_s2      <= cpu_s1;
			mem_s2      <= mem_s1;
			rise_s2     <= rise[LoadW-1:0];
			free_s2     <= free_s1;
			leak_one_s2 <= back == '0;
		end
	end

	anomaly_kind_t       head;
	logic [NumKinds-1:0] rest;
	logic                move;
	logic                head_last;
	logic [FreeW-1:0]    lost;
	severity_t           head_sev;
	logic [MetricW-1:0]  head_metric;

	always_comb begin
		head = KIND_OVERLOAD;
		for (int i = NumKinds - 1; i >= 0; i--) begin
			if (mask_s2[i]) begin
				head = anomaly_kind_t'(3'(i));
			end
		end
		rest = mask_s2;
		rest[head] = 1'b0;
		head_last = rest == '0;
		move = (mask_s2 != '0) && (!m_axis_tvalid || m_axis_tready);
		take_s2 = (mask_s2 == '0) || (move && head_last);

		lost = leak_one_s2 ? '0 : hist_rdata - free_s2;

		case (head)
			KIND_CPU_SPIKE: begin
				head_sev    = cpu_sev_s2;
				head_metric = MetricW'(cpu_s2);
			end
			KIND_CPU_RAMP: begin
				head_sev    = ramp_sev_s2;
				head_metric = MetricW'(rise_s2);
			end
			KIND_MEM_SPIKE: begin
				head_sev    = mem_sev_s2;
				head_metric = MetricW'(mem_s2);
			end
			KIND_MEM_LEAK: begin
				head_sev    = (lost > LeakHighBytes) ? SEV_HIGH : SEV_MEDIUM;
				head_metric = lost[FreeW-1:MibShift];
			end
			KIND_OVERLOAD: begin
				head_sev    = SEV_CRITICAL;
				head_metric = MetricW'((cpu_s2 > mem_s2) ? cpu_s2 : mem_s2);
			end
			default: begin
				head_sev    = SEV_LOW;
				head_metric = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2 <= '0;
		end else if (adv_s1) begin
			mask_s2 <= fire_mask;
		end else if (move) begin
			mask_s2 <= rest;
		end
	end

	// Output register.
	anomaly_kind_t      out_kind_q;
	severity_t          out_sev_q;
	logic [MetricW-1:0] out_metric_q;
	logic               out_last_q;
	logic               out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_kind_q   <= head;
			out_sev_q    <= head_sev;
			out_metric_q <= head_metric;
			out_last_q   <= head_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {{(OutDataW - 3 - 2 - MetricW){1'b0}}, out_metric_q, out_sev_q,
		out_kind_q};

	// The first sample after reset has nothing to ramp from.
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && samples_q == '0) |=> !mask_s2[KIND_CPU_RAMP])
		else $error("ramp reported without a previous sample");

	assert property (@(posedge clk) disable iff (!arst_n)
		(samples_q <= SW'(HISTORY_DEPTH)) && (fall_run_q <= samples_q))
		else $error("sample or fall counter out of range");

	// A report stage with work left never lets a new sample in.
	assert property (@(posedge clk) disable iff (!arst_n)
		(mask_s2 != '0 && !move) |-> !adv_s1)
		else $error("sample advanced over pending reports");

	assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && fire_mask == '0) |=> (mask_s2 == '0 && !move))
		else $error("report emitted for a quiet sample");

endmodule

### dv/load_anomaly_detector_test.sv
// Self-checking bench for load_anomaly_detector: random and directed samples
// go in on the input stream, and every report beat is checked against a
// behavioral predictor. Depends on lad_pkg and the detector RTL.
`timescale 1ns / 1ps

module load_anomaly_detector_test;

	import lad_pkg::*;

	localparam int HistDepth = HistoryDepthDefault;
	localparam int DrainCycles = 8;
	localparam int MaxPrinted = 40;
	localparam logic [CfgIndexW-1:0] RegIndexUnused = 3'd7;
	localparam logic [FreeW-1:0] FreeMax = '1;
	localparam logic [FreeW-1:0] HalfGib = 48'd536870912;

	typedef struct packed {
		logic [LoadW-1:0] cpu_load;
		logic [LoadW-1:0] mem_load;
		logic [FreeW-1:0] free_bytes;
	} load_sample_t;

	typedef struct {
		anomaly_kind_t kind;
		severity_t sev;
		logic [MetricW-1:0] metric;
		logic is_last;
	} anomaly_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [InDataW-1:0] s_axis_tdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [OutDataW-1:0] m_axis_tdata;
	logic m_axis_tlast;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CfgIndexW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	load_anomaly_detector DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	load_sample_t sample_queue[$];
	anomaly_report_t expected_reports[$];
	int pending_samples = 0;
	int error_count = 0;
	int send_idle_pct = 16;
	int recv_idle_pct = 57;
	logic s_beat_taken = 1'b0;

	// Register copies as the detector sees them.
	logic [LoadW-1:0] cpu_thr_cfg = CpuThresholdReset;
	logic [RunW-1:0] cpu_need_cfg = CpuRunNeededReset;
	logic [LoadW-1:0] mem_thr_cfg = MemThresholdReset;
	logic [RunW-1:0] mem_need_cfg = MemRunNeededReset;
	logic [LoadW-1:0] ramp_cfg = RampDeltaReset;
	logic [WindowW-1:0] leak_cfg = LeakWindowReset;

	// Detector state as predicted.
	logic [RunW-1:0] cpu_run_cnt = '0;
	logic [RunW-1:0] mem_run_cnt = '0;
	logic [LoadW-1:0] prev_cpu = '0;
	int unsigned seen_cnt = 0;
	int unsigned fall_cnt = 0;
	logic [FreeW-1:0] free_hist [HistDepth];
	logic [5:0] hist_ptr = '0;

	// Stimulus generator state.
	logic [FreeW-1:0] gen_free = '0;
	logic [LoadW-1:0] gen_cpu_prev = '0;

	task automatic report_error(input string what, input longint got, input longint want);
		error_count++;
		if (error_count <= MaxPrinted) begin
			$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
		end
	endtask

	function automatic severity_t overshoot_grade(input logic [LoadW-1:0] value,
			input logic [LoadW-1:0] thr);
		int over;
		over = int'(value) - int'(thr);
		if (over >= 80) begin
			return SEV_CRITICAL;
		end else if (over >= 50) begin
			return SEV_HIGH;
		end else if (over >= 20) begin
			return SEV_MEDIUM;
		end
		return SEV_LOW;
	endfunction

	function automatic void push_report(input anomaly_kind_t kind, input severity_t sev,
			input logic [MetricW-1:0] metric);
		anomaly_report_t r;
		r.kind = kind;
		r.sev = sev;
		r.metric = metric;
		r.is_last = 1'b0;
		expected_reports.insert(expected_reports.size(), r);
	endfunction

	// Updates the predicted state with one sample and queues its reports.
	task automatic compute_reports(input logic [LoadW-1:0] cpu, input logic [LoadW-1:0] mem,
			input logic [FreeW-1:0] freeb);
		bit had_prev;
		int first_new;
		int rise;
		int unsigned win;
		logic [5:0] oldest;
		logic [FreeW-1:0] lost;
		had_prev = seen_cnt > 0;
		first_new = expected_reports.size();
		if (had_prev) begin
			if (freeb < free_hist[hist_ptr]) begin
				if (fall_cnt < HistDepth) fall_cnt++;
			end else begin
				fall_cnt = 0;
			end
			hist_ptr = hist_ptr + 6'd1;
		end else begin
			fall_cnt = 0;
			hist_ptr = '0;
		end
		free_hist[hist_ptr] = freeb;
		if (seen_cnt < HistDepth) seen_cnt++;

		if (cpu >= cpu_thr_cfg) begin
			if (cpu_run_cnt != RunMax) cpu_run_cnt++;
		end else begin
			cpu_run_cnt = '0;
		end
		if (cpu_run_cnt >= cpu_need_cfg) begin
			push_report(KIND_CPU_SPIKE, overshoot_grade(cpu, cpu_thr_cfg), MetricW'(cpu));
		end

		if (had_prev) begin
			rise = int'(cpu) - int'(prev_cpu);
			if (rise >= int'(ramp_cfg)) begin
				push_report(KIND_CPU_RAMP, (rise >= 2 * int'(ramp_cfg)) ? SEV_HIGH : SEV_MEDIUM,
					MetricW'(rise));
			end
		end
		prev_cpu = cpu;

		if (mem >= mem_thr_cfg) begin
			if (mem_run_cnt != RunMax) mem_run_cnt++;
		end else begin
			mem_run_cnt = '0;
		end
		if (mem_run_cnt >= mem_need_cfg) begin
			push_report(KIND_MEM_SPIKE, overshoot_grade(mem, mem_thr_cfg), MetricW'(mem));
		end

		// A window of zero behaves as a window of one sample.
		win = (leak_cfg == 0) ? 1 : leak_cfg;
		if (win <= seen_cnt && fall_cnt >= win - 1) begin
			oldest = hist_ptr - 6'(win - 1);
			lost = free_hist[oldest] - freeb;
			push_report(KIND_MEM_LEAK, (lost > LeakHighBytes) ? SEV_HIGH : SEV_MEDIUM,
				MetricW'(lost >> MibShift));
		end

		if (cpu >= cpu_thr_cfg && mem >= mem_thr_cfg) begin
			push_report(KIND_OVERLOAD, SEV_CRITICAL, MetricW'((cpu > mem) ? cpu : mem));
		end

		if (expected_reports.size() > first_new) begin
			expected_reports[expected_reports.size() - 1].is_last = 1'b1;
		end
	endtask

	always @(negedge clk) begin : driver
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= $urandom_range(99) >= recv_idle_pct;
			if (!s_axis_tvalid || s_beat_taken) begin
				if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_axis_tdata <= {4'd0, sample_queue[0].free_bytes,
						sample_queue[0].mem_load, sample_queue[0].cpu_load};
					sample_queue.delete(0);
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		anomaly_report_t want;
		if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
			if (expected_reports.size() == 0) begin
				report_error("report beat with none expected, metric", m_axis_tdata[32:5], 0);
			end else begin
				want = expected_reports[0];
				expected_reports.delete(0);
				if (m_axis_tdata[2:0] !== want.kind) begin
					report_error("anomaly_kind", m_axis_tdata[2:0], want.kind);
				end
				if (m_axis_tdata[4:3] !== want.sev) begin
					report_error("severity", m_axis_tdata[4:3], want.sev);
				end
				if (m_axis_tdata[32:5] !== want.metric) begin
					report_error("metric", m_axis_tdata[32:5], want.metric);
				end
				if (m_axis_tlast !== want.is_last) begin
					report_error("tlast", m_axis_tlast, want.is_last);
				end
			end
		end
		if (s_axis_tvalid && s_axis_tready === 1'b1) begin
			compute_reports(s_axis_tdata[9:0], s_axis_tdata[19:10], s_axis_tdata[67:20]);
			pending_samples--;
		end
		s_beat_taken <= s_axis_tvalid && s_axis_tready === 1'b1;
	end

	task automatic queue_sample(input int cpu, input int mem, input logic [FreeW-1:0] freeb);
		load_sample_t smp;
		smp.cpu_load = cpu[LoadW-1:0];
		smp.mem_load = mem[LoadW-1:0];
		smp.free_bytes = freeb;
		sample_queue.insert(sample_queue.size(), smp);
		pending_samples++;
		gen_cpu_prev = smp.cpu_load;
	endtask

	function automatic logic [LoadW-1:0] pick_load(input logic [LoadW-1:0] thr);
		int v;
		case ($urandom_range(3))
			0: v = $urandom_range(1023);
			1: v = int'(thr) + int'($urandom_range(120)) - 40;
			2: v = $urandom_range(1) ? 1023 : 0;
			default: v = int'(gen_cpu_prev) + int'(ramp_cfg) + int'($urandom_range(4)) - 2;
		endcase
		if (v < 0) v = 0;
		if (v > 1023) v = 1023;
		return v[LoadW-1:0];
	endfunction

	function automatic logic [FreeW-1:0] random_free();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// Next value of a falling free-memory run; it falls strictly until it reaches zero.
	function automatic logic [FreeW-1:0] next_fall();
		logic [FreeW-1:0] step;
		case ($urandom_range(3))
			0: step = $urandom_range(255) + 1;
			1: step = $urandom_range(32'h000F_FFFF) + 1;
			2: step = $urandom_range(32'h07FF_FFFF) + 1;
			default: step = {8'($urandom), 32'($urandom)} + 1;
		endcase
		if (gen_free > step) begin
			gen_free = gen_free - step;
		end else begin
			gen_free = gen_free >> 1;
		end
		return gen_free;
	endfunction

	function automatic logic [FreeW-1:0] noise_free();
		case ($urandom_range(2))
			0: gen_free = gen_free;
			1: gen_free = random_free();
			default: gen_free = gen_free + $urandom_range(4095);
		endcase
		return gen_free;
	endfunction

	task automatic queue_falling_run(input int len);
		gen_free = random_free();
		queue_sample(pick_load(cpu_thr_cfg), pick_load(mem_thr_cfg), gen_free);
		for (int i = 1; i < len; i++) begin
			queue_sample(pick_load(cpu_thr_cfg), pick_load(mem_thr_cfg), next_fall());
		end
	endtask

	// Mostly falling runs of 2 up to 3 more than the leak window (capped at 16), with noise between.
	task automatic queue_mixed(input int count);
		int left;
		int len;
		int span;
		left = count;
		span = (leak_cfg > 16) ? 16 : leak_cfg;
		while (left > 0) begin
			if ($urandom_range(3) != 0) begin
				len = $urandom_range(span + 3, 2);
				if (len > left) len = left;
				queue_falling_run(len);
			end else begin
				len = 1;
				queue_sample(pick_load(cpu_thr_cfg), pick_load(mem_thr_cfg), noise_free());
			end
			left -= len;
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk); while (pending_samples != 0 || expected_reports.size() != 0);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic write_register(input logic [CfgIndexW-1:0] idx, input int unsigned value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CfgDataW-1:0];
		case (idx)
			REG_CPU_THRESHOLD: cpu_thr_cfg = value[LoadW-1:0];
			REG_CPU_RUN_NEEDED: cpu_need_cfg = value[RunW-1:0];
			REG_MEM_THRESHOLD: mem_thr_cfg = value[LoadW-1:0];
			REG_MEM_RUN_NEEDED: mem_need_cfg = value[RunW-1:0];
			REG_RAMP_DELTA: ramp_cfg = value[LoadW-1:0];
			REG_LEAK_WINDOW: leak_cfg = value[WindowW-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input int unsigned cpu_thr, input int unsigned cpu_need,
			input int unsigned mem_thr, input int unsigned mem_need,
			input int unsigned ramp, input int unsigned leak);
		wait_idle();
		write_register(REG_CPU_THRESHOLD, cpu_thr);
		write_register(REG_CPU_RUN_NEEDED, cpu_need);
		write_register(REG_MEM_THRESHOLD, mem_thr);
		write_register(REG_MEM_RUN_NEEDED, mem_need);
		write_register(REG_RAMP_DELTA, ramp);
		write_register(REG_LEAK_WINDOW, leak);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: spike grading boundaries, ramp limits and leak edges.
		queue_sample(0, 0, FreeMax);
		queue_sample(1023, 1023, FreeMax - 1);
		queue_sample(1023, 1023, FreeMax - 2);
		queue_sample(1023, 1023, FreeMax - 3);
		queue_sample(920, 950, FreeMax - 4);
		queue_sample(979, 919, FreeMax - 5);
		queue_sample(980, 920, FreeMax - 6);
		queue_sample(949, 949, FreeMax - 7);
		queue_sample(950, 1000, FreeMax - 8);
		queue_sample(899, 899, FreeMax - 9);
		// Exactly half a GiB lost over the window is still medium; one byte more is high.
		queue_sample(899, 899, FreeMax - 1 - HalfGib);
		queue_sample(899, 899, FreeMax - 3 - HalfGib);
		queue_sample(0, 0, FreeMax - 3 - HalfGib);
		queue_sample(0, 0, '0);
		queue_sample(300, 0, '0);
		queue_sample(599, 0, 48'd1);
		queue_sample(0, 0, 48'h5555_5555_5555);
		queue_sample(600, 0, 48'hAAAA_AAAA_AAAA);
		queue_sample(1023, 1023, 48'h0000_0000_0001);
		queue_sample(0, 0, FreeMax);

		// A write to an index with no register behind it must change nothing.
		wait_idle();
		write_register(RegIndexUnused, 10'h3FF);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		queue_mixed(10);

		apply_settings(500, 1, 600, 2, 150, 4);
		queue_mixed(20);
		wait_idle();
		queue_mixed(20);

		// Lowest settings: each sample raises all but the ramp report, which needs cpu not to fall.
		apply_settings(0, 0, 0, 0, 0, 0);
		queue_mixed(20);

		send_idle_pct = 57;
		recv_idle_pct = 16;
		apply_settings(1023, 255, 1023, 255, 1023, 1);
		queue_mixed(15);

		apply_settings(700, 8, 300, 5, 1, 127);
		queue_mixed(15);

		// Every sample counts toward both runs; the full-depth window needs a
		// long falling run.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		apply_settings(0, 255, 0, 254, 700, 64);
		queue_falling_run(66);

		wait_idle();
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#1_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

### sim.f
hdl/lad_pkg.sv
hdl/lad_ram.sv
hdl/load_anomaly_detector.sv
dv/load_anomaly_detector_test.sv
